### hdl/sim_pkg.sv
package sim_pkg;

	localparam int COORD_BITS_DEF  = 31;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int SEQ_BITS        = 16;
	localparam int GRP_BITS        = 32;
	localparam int CFG_BITS        = 31;
	localparam int CFG_IDX_BITS    = 2;

	localparam logic [CFG_IDX_BITS-1:0] REG_GAP_TOLERANCE   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_LIMIT_ON   = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_GROUP_WIDTH = 2'd2;

	typedef enum logic [1:0] {
		PH_CLOSE,
		PH_LABEL,
		PH_FINAL
	} sim_phase_t;

	function automatic int in_width(input int coord_bits);
		return ((SEQ_BITS + 2 * coord_bits + 7) / 8) * 8;
	endfunction

	function automatic int out_width(input int coord_bits);
		return ((GRP_BITS + SEQ_BITS + 2 * coord_bits + 7) / 8) * 8;
	endfunction

	function automatic int entry_width(input int coord_bits);
		return 2 * (1 + GRP_BITS + SEQ_BITS + 2 * coord_bits);
	endfunction

endpackage

### hdl/sim_queue.sv
module sim_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	assign full    = (count_q == CNT_BITS'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] p);
		return (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

### hdl/sim_front.sv
module sim_front #(
	parameter int COORD_BITS = sim_pkg::COORD_BITS_DEF
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           s_tvalid,
	output logic                                           s_tready,
	input  logic [sim_pkg::in_width(COORD_BITS)-1:0]       s_tdata,
	input  logic                                           s_tuser,
	input  logic                                           s_tlast,
	input  logic                                           cfg_valid,
	input  logic [sim_pkg::CFG_IDX_BITS-1:0]               cfg_index,
	input  logic [sim_pkg::CFG_BITS-1:0]                   cfg_data,
	input  logic                                           q_full,
	output logic                                           q_push,
	output logic [sim_pkg::entry_width(COORD_BITS)-1:0]    q_wdata
);

	import sim_pkg::*;

	localparam int CMPW = ((COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS) + 1;

	logic [CFG_BITS-1:0]   gap_tol_q;
	logic                  size_lim_q;
	logic [CFG_BITS-1:0]   max_width_q;

	logic                  have_q;
	logic [SEQ_BITS-1:0]   prev_seq_q;
	logic [COORD_BITS-1:0] prev_end_q;
	logic                  prev_sign_q;
	logic [COORD_BITS-1:0] grp_start_q;
	logic [COORD_BITS-1:0] grp_max_end_q;
	logic [GRP_BITS-1:0]   grp_count_q;

	logic [SEQ_BITS-1:0]   seq;
	logic [COORD_BITS-1:0] st;
	logic [COORD_BITS-1:0] en;
	logic                  sg;
	logic                  fin;
	logic                  accept;
	logic [COORD_BITS-1:0] gap;
	logic [COORD_BITS-1:0] span;
	logic                  gap_split;
	logic                  width_split;
	logic                  split;
	logic                  open_grp;
	logic [GRP_BITS-1:0]   count_inc;
	logic [GRP_BITS-1:0]   count_new;
	logic [COORD_BITS-1:0] start_new;
	logic [COORD_BITS-1:0] max_end_new;

	assign seq = s_tdata[SEQ_BITS-1:0];
	assign st  = s_tdata[SEQ_BITS +: COORD_BITS];
	assign en  = s_tdata[SEQ_BITS+COORD_BITS +: COORD_BITS];
	assign sg  = s_tuser;
	assign fin = s_tlast;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign q_push   = accept;

	assign gap  = st - prev_end_q - 1'b1;
	assign span = en - grp_start_q;

	assign gap_split   = (st > prev_end_q) && (CMPW'(gap) > CMPW'(gap_tol_q));
	assign width_split = size_lim_q && (en >= grp_start_q)
		&& (CMPW'(span) >= CMPW'(max_width_q));
	assign split = have_q && ((seq != prev_seq_q) || gap_split
		|| (sg != prev_sign_q) || width_split);
	assign open_grp = !have_q || split;

	assign count_inc   = (&grp_count_q) ? grp_count_q : grp_count_q + 1'b1;
	assign count_new   = open_grp ? count_inc : grp_count_q;
	assign start_new   = open_grp ? st : grp_start_q;
	assign max_end_new = (open_grp || (en > grp_max_end_q)) ? en : grp_max_end_q;

	// Closed group first, then the label group, then the group as it stands after this item.
	assign q_wdata = {split, grp_count_q, prev_seq_q, grp_start_q, grp_max_end_q,
		fin, count_new, seq, start_new, max_end_new};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_tol_q   <= '0;
			size_lim_q  <= 1'b0;
			max_width_q <= CFG_BITS'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_GAP_TOLERANCE:   gap_tol_q   <= cfg_data;
				REG_SIZE_LIMIT_ON:   size_lim_q  <= cfg_data[0];
				REG_MAX_GROUP_WIDTH: max_width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q        <= 1'b0;
			prev_seq_q    <= '0;
			prev_end_q    <= '0;
			prev_sign_q   <= 1'b0;
			grp_start_q   <= '0;
			grp_max_end_q <= '0;
			grp_count_q   <= '0;
		end else if (accept) begin
			if (fin) begin
				have_q        <= 1'b0;
				prev_seq_q    <= '0;
				prev_end_q    <= '0;
				prev_sign_q   <= 1'b0;
				grp_start_q   <= '0;
				grp_max_end_q <= '0;
				grp_count_q   <= '0;
			end else begin
				have_q        <= 1'b1;
				prev_seq_q    <= seq;
				prev_end_q    <= en;
				prev_sign_q   <= sg;
				grp_start_q   <= start_new;
				grp_max_end_q <= max_end_new;
				grp_count_q   <= count_new;
			end
		end
	end

endmodule

### hdl/sim_back.sv
module sim_back #(
	parameter int COORD_BITS = sim_pkg::COORD_BITS_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         q_empty,
	input  logic [sim_pkg::entry_width(COORD_BITS)-1:0]  q_rdata,
	output logic                                         q_pop,
	output logic                                         m_tvalid,
	input  logic                                         m_tready,
	output logic [sim_pkg::out_width(COORD_BITS)-1:0]    m_tdata,
	output logic                                         m_tuser,
	output logic                                         m_tlast
);

	import sim_pkg::*;

	localparam int OUT_W = out_width(COORD_BITS);

	sim_phase_t ph_q;
	sim_phase_t ph_d;
	sim_phase_t cur;

	logic                  close_v;
	logic [GRP_BITS-1:0]   close_grp;
	logic [SEQ_BITS-1:0]   close_seq;
	logic [COORD_BITS-1:0] close_st;
	logic [COORD_BITS-1:0] close_en;
	logic                  fin;
	logic [GRP_BITS-1:0]   lbl_grp;
	logic [SEQ_BITS-1:0]   fin_seq;
	logic [COORD_BITS-1:0] fin_st;
	logic [COORD_BITS-1:0] fin_en;

	logic                  fire;
	logic [GRP_BITS-1:0]   o_grp;
	logic [SEQ_BITS-1:0]   o_seq;
	logic [COORD_BITS-1:0] o_st;
	logic [COORD_BITS-1:0] o_en;

	assign {close_v, close_grp, close_seq, close_st, close_en,
		fin, lbl_grp, fin_seq, fin_st, fin_en} = q_rdata;

	assign m_tvalid = !q_empty;
	assign fire     = m_tvalid && m_tready;
	assign cur      = ((ph_q == PH_CLOSE) && !close_v) ? PH_LABEL : ph_q;
	assign m_tdata  = OUT_W'({o_en, o_st, o_seq, o_grp});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_CLOSE;
		end else begin
			ph_q <= ph_d;
		end
	end

	always_comb begin
		ph_d    = ph_q;
		q_pop   = 1'b0;
		m_tuser = 1'b0;
		m_tlast = 1'b0;
		o_grp   = lbl_grp;
		o_seq   = '0;
		o_st    = '0;
		o_en    = '0;
		case (cur)
			PH_CLOSE: begin
				m_tuser = 1'b1;
				o_grp   = close_grp;
				o_seq   = close_seq;
				o_st    = close_st;
				o_en    = close_en;
				if (fire) begin
					ph_d = PH_LABEL;
				end
			end
			PH_LABEL: begin
				m_tlast = !fin;
				if (fire) begin
					if (fin) begin
						ph_d = PH_FINAL;
					end else begin
						ph_d  = PH_CLOSE;
						q_pop = 1'b1;
					end
				end
			end
			PH_FINAL: begin
				m_tuser = 1'b1;
				m_tlast = 1'b1;
				o_seq   = fin_seq;
				o_st    = fin_st;
				o_en    = fin_en;
				if (fire) begin
					ph_d  = PH_CLOSE;
					q_pop = 1'b1;
				end
			end
			default: begin
				ph_d = PH_CLOSE;
			end
		endcase
	end

endmodule

### hdl/sorted_interval_merger.sv
// An interval's first result is offered once its registered queue entry is at the queue head.
// Throughput: the front takes one interval per cycle while its queue has room; the output
// gives one result per cycle while m_tready is high, so an interval gives one to three results
// (two typical: closed region plus label), and the single output port sets the sustained rate.
// Reset: arst_n clears the group state, the queue and the output phase; registers return to
// a gap tolerance of 0, size limit off and a maximum group width of 1.
module sorted_interval_merger #(
	parameter int COORD_BITS  = sim_pkg::COORD_BITS_DEF,
	parameter int QUEUE_DEPTH = sim_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	// seq_id, iv_start, iv_end, zero padding
	input  logic [sim_pkg::in_width(COORD_BITS)-1:0] s_tdata,
	// strand_sign
	input  logic                                     s_tuser,
	input  logic                                     s_tlast,
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	// group_number, region_seq, region_start, region_end, zero padding
	output logic [sim_pkg::out_width(COORD_BITS)-1:0] m_tdata,
	// kind
	output logic                                     m_tuser,
	output logic                                     m_tlast,
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [sim_pkg::CFG_IDX_BITS-1:0]         cfg_index,
	input  logic [sim_pkg::CFG_BITS-1:0]             cfg_data
);

	import sim_pkg::*;

	localparam int ENTRY_W = entry_width(COORD_BITS);

	logic               q_push;
	logic               q_pop;
	logic               q_full;
	logic               q_empty;
	logic [ENTRY_W-1:0] q_wdata;
	logic [ENTRY_W-1:0] q_rdata;

	assign cfg_ready = 1'b1;

	sim_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	sim_queue #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.pop   (q_pop),
		.rdata (q_rdata),
		.full  (q_full),
		.empty (q_empty)
	);

	sim_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_rdata (q_rdata),
		.q_pop   (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule

### verif/sorted_interval_merger_tb.sv
module sorted_interval_merger_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sim_pkg::*;

	localparam int COORD_BITS = COORD_BITS_DEF;
	localparam int IN_W = in_width(COORD_BITS);
	localparam int OUT_W = out_width(COORD_BITS);
	localparam longint COORD_MAX = (longint'(1) << COORD_BITS) - 1;
	localparam int CYCLE_LIMIT = 300000;

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef struct {
		bit                kind;
		bit [GRP_BITS-1:0] group_number;
		bit [SEQ_BITS-1:0] region_seq;
		coord_t            region_start;
		coord_t            region_end;
		bit                run_last;
	} merge_result_t;

	logic                    clk;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [IN_W-1:0]         s_tdata;
	logic                    s_tuser;
	logic                    s_tlast;
	logic                    m_tvalid;
	logic                    m_tready;
	logic [OUT_W-1:0]        m_tdata;
	logic                    m_tuser;
	logic                    m_tlast;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0]     cfg_data;

	// Register copies and group state held by the predictor.
	bit [CFG_BITS-1:0] gap_tol;
	bit                width_split_on;
	bit [CFG_BITS-1:0] width_limit;
	bit                open_set;
	bit [SEQ_BITS-1:0] last_seq;
	coord_t            held_end;
	bit                held_sign;
	coord_t            grp_first_start;
	coord_t            grp_max_end;
	bit [GRP_BITS-1:0] grp_count;

	merge_result_t awaited_results[$];

	int  error_count = 0;
	int  cycle_count = 0;
	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	int  hold_request = 0;
	int  hold_left = 0;

	sorted_interval_merger dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	function automatic merge_result_t region_record();
		merge_result_t r;
		r.kind = 1'b1;
		r.group_number = grp_count;
		r.region_seq = last_seq;
		r.region_start = grp_first_start;
		r.region_end = grp_max_end;
		r.run_last = 1'b0;
		return r;
	endfunction

	task automatic start_group(input coord_t st, input coord_t en);
		if (grp_count != '1)
			grp_count = grp_count + 1'b1;
		grp_first_start = st;
		grp_max_end = en;
	endtask

	task automatic merge_interval(input bit [SEQ_BITS-1:0] seq, input coord_t st,
			input coord_t en, input bit sg, input bit fin);
		merge_result_t step_results[$];
		merge_result_t label;
		bit split;
		split = 1'b0;
		if (!open_set) begin
			start_group(st, en);
		end else begin
			if (seq != last_seq)
				split = 1'b1;
			if (st > held_end && (st - held_end - 1'b1) > gap_tol)
				split = 1'b1;
			if (sg != held_sign)
				split = 1'b1;
			if (width_split_on && en >= grp_first_start &&
					(en - grp_first_start) >= width_limit)
				split = 1'b1;
			if (split) begin
				step_results.push_back(region_record());
				start_group(st, en);
			end else if (en > grp_max_end) begin
				grp_max_end = en;
			end
		end
		open_set = 1'b1;
		last_seq = seq;
		held_end = en;
		held_sign = sg;
		label = '{kind: 1'b0, group_number: grp_count, region_seq: '0,
			region_start: '0, region_end: '0, run_last: 1'b0};
		step_results.push_back(label);
		if (fin) begin
			step_results.push_back(region_record());
			open_set = 1'b0;
			last_seq = '0;
			held_end = '0;
			held_sign = 1'b0;
			grp_first_start = '0;
			grp_max_end = '0;
			grp_count = '0;
		end
		step_results[$].run_last = 1'b1;
		foreach (step_results[i])
			awaited_results.push_back(step_results[i]);
	endtask

	task automatic check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin : check_results
		merge_result_t want;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			if (awaited_results.size() == 0) begin
				$error("result transaction with no expected result pending");
				error_count++;
			end else begin
				want = awaited_results.pop_front();
				check_field("kind", want.kind, m_tuser);
				check_field("group_number", want.group_number, m_tdata[31:0]);
				check_field("region_seq", want.region_seq, m_tdata[47:32]);
				check_field("region_start", want.region_start,
					m_tdata[48 +: COORD_BITS]);
				check_field("region_end", want.region_end,
					m_tdata[48 + COORD_BITS +: COORD_BITS]);
				check_field("run_last", want.run_last, m_tlast);
			end
		end
	end

	task automatic send_interval(input bit [SEQ_BITS-1:0] seq, input coord_t st,
			input coord_t en, input bit sg, input bit fin);
		logic [IN_W-1:0] word;
		word = '0;
		word[15:0] = seq;
		word[16 +: COORD_BITS] = st;
		word[16 + COORD_BITS +: COORD_BITS] = en;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		s_tuser <= sg;
		s_tlast <= fin;
		do @(posedge clk); while (!s_tready);
		merge_interval(seq, st, en, sg, fin);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic configure(input bit [CFG_BITS-1:0] gap, input bit limit_on,
			input bit [CFG_BITS-1:0] max_width);
		bit [CFG_BITS-1:0] values[3];
		logic [CFG_IDX_BITS-1:0] regs[3];
		values = '{gap, CFG_BITS'(limit_on), max_width};
		regs = '{REG_GAP_TOLERANCE, REG_SIZE_LIMIT_ON, REG_MAX_GROUP_WIDTH};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= values[i];
			do @(posedge clk); while (!cfg_ready);
			case (regs[i])
				REG_GAP_TOLERANCE:   gap_tol = values[i];
				REG_SIZE_LIMIT_ON:   width_split_on = values[i][0];
				REG_MAX_GROUP_WIDTH: width_limit = values[i];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	// Sorted intervals with random content; offsets straddle the gap tolerance.
	task automatic send_data_set(input int n_items, input int gap_hint);
		bit [SEQ_BITS-1:0] seq;
		bit sg;
		longint cur_st, cur_en, prev_en, cand;
		seq = SEQ_BITS'($urandom_range(0, 65535));
		sg = 1'($urandom_range(0, 1));
		cur_st = $urandom_range(0, int'(COORD_MAX - (1 << 20)));
		prev_en = cur_st;
		for (int i = 0; i < n_items; i++) begin
			if (i > 0) begin
				if ($urandom_range(9) == 0 && seq != 16'hFFFF)
					seq = seq + 1'b1;
				if ($urandom_range(9) == 0)
					sg = ~sg;
				cand = prev_en + 1 + longint'($urandom_range(0, 2 * gap_hint + 6)) - 4;
				if (cand > cur_st)
					cur_st = cand;
			end
			cur_en = cur_st + $urandom_range(0, 24);
			if ($urandom_range(19) == 0)
				cur_en = cur_st - $urandom_range(0, 5);
			if (cur_en < 0)
				cur_en = 0;
			if (cur_en > COORD_MAX)
				cur_en = COORD_MAX;
			send_interval(seq, coord_t'(cur_st), coord_t'(cur_en), sg, i == n_items - 1);
			prev_en = cur_en;
		end
	endtask

	task automatic test_directed();
		localparam coord_t TOP = coord_t'(COORD_MAX);
		send_interval(16'd0, 0, 0, 1'b0, 1'b0);
		send_interval(16'd0, 1, 5, 1'b0, 1'b0);
		send_interval(16'd0, 7, 9, 1'b0, 1'b0);
		send_interval(16'd0, 3, 4, 1'b0, 1'b0);
		send_interval(16'd0, 10, 12, 1'b1, 1'b0);
		send_interval(16'hFFFF, 10, 12, 1'b1, 1'b0);
		send_interval(16'hFFFF, TOP, TOP, 1'b1, 1'b1);
		send_interval(16'hFFFF, TOP, TOP, 1'b1, 1'b1);
		wait_drained();
		configure(CFG_BITS'(COORD_MAX), 1'b1, '0);
		send_interval(16'd5, 100, 200, 1'b0, 1'b0);
		send_interval(16'd5, 150, 120, 1'b0, 1'b0);
		send_interval(16'd5, 151, 149, 1'b0, 1'b0);
		send_interval(16'd5, TOP, TOP, 1'b0, 1'b1);
		wait_drained();
		configure(CFG_BITS'(3), 1'b1, CFG_BITS'(COORD_MAX));
		send_interval(16'd1, 0, 0, 1'b0, 1'b0);
		send_interval(16'd1, 4, TOP, 1'b0, 1'b0);
		send_interval(16'd1, 10, TOP - 1'b1, 1'b0, 1'b1);
		wait_drained();
		configure('0, 1'b1, CFG_BITS'(1));
		send_interval(16'd2, 0, 0, 1'b0, 1'b0);
		send_interval(16'd2, 0, 0, 1'b0, 1'b0);
		send_interval(16'd2, 0, 1, 1'b0, 1'b1);
		wait_drained();
	endtask

	task automatic test_random_phase(input int idle_pct, input int stall_pct,
			input int n_items);
		bit [CFG_BITS-1:0] gap;
		int sent, len, hint;
		wait_drained();
		case ($urandom_range(3))
			0: gap = '0;
			1: gap = CFG_BITS'(COORD_MAX);
			default: gap = CFG_BITS'($urandom_range(1, 20));
		endcase
		configure(gap, 1'($urandom_range(0, 1)),
			($urandom_range(4) == 0) ? CFG_BITS'(COORD_MAX)
				: CFG_BITS'($urandom_range(1, 64)));
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		hint = (gap > 40) ? 40 : int'(gap);
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 15) begin
				send_interval(SEQ_BITS'($urandom_range(0, 65535)), coord_t'($urandom),
					coord_t'($urandom), 1'($urandom_range(0, 1)),
					$urandom_range(7) == 0);
				sent++;
			end else begin
				len = $urandom_range(1, 8);
				send_data_set(len, hint);
				sent += len;
			end
		end
	endtask

	task automatic test_backpressure();
		wait_drained();
		configure(CFG_BITS'(4), 1'b0, CFG_BITS'(1));
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 80;
		send_data_set(15, 4);
		wait_drained();
		send_data_set(6, 4);
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		s_tlast <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		gap_tol = '0;
		width_split_on = 1'b0;
		width_limit = CFG_BITS'(1);
		open_set = 1'b0;
		last_seq = '0;
		held_end = '0;
		held_sign = 1'b0;
		grp_first_start = '0;
		grp_max_end = '0;
		grp_count = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_phase(0, 0, 30);
		test_random_phase(45, 0, 30);
		test_random_phase(0, 45, 30);
		test_random_phase(20, 20, 30);
		test_backpressure();

		wait_drained();
		repeat (10) @(posedge clk);
		if (error_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

### files.f
hdl/sim_pkg.sv
hdl/sim_queue.sv
hdl/sim_front.sv
hdl/sim_back.sv
hdl/sorted_interval_merger.sv
verif/sorted_interval_merger_tb.sv
